// ===== hw/rtl/fct_pkg.sv =====
`timescale 1ns / 1ps

package fct_pkg;

  // grid limits and number format
  localparam int MAX_COLS  = 1024;
  localparam int MAX_ROWS  = 1024;
  localparam int FLUX_BITS = 32;

  // raster position counters hold 0 .. MAX_COLS+1
  localparam int POS_W = $clog2(MAX_COLS + 2);
  localparam int CFG_W = 11;

  // line buffer depths and address widths
  localparam int X1_DEPTH  = MAX_COLS + 2;
  localparam int EMF_DEPTH = MAX_COLS + 1;
  localparam int X1_AW     = $clog2(X1_DEPTH);
  localparam int EMF_AW    = $clog2(EMF_DEPTH);

  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(256);
  localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(256);

  // apb register map, one 32-bit word per register
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  typedef enum logic {
    REG_COLS = 1'b0,
    REG_ROWS = 1'b1
  } reg_idx_t;

  typedef logic signed [FLUX_BITS-1:0] flux_t;

  typedef struct packed {
    flux_t x1_b2_flux;
    flux_t x2_b1_flux;
  } src_t;

  typedef struct packed {
    flux_t       new_x1_b2;
    logic        x1_out_valid;
    logic [9:0]  x1_out_row;
    logic [10:0] x1_out_col;
    flux_t       new_x2_b1;
    logic        x2_out_valid;
    logic [10:0] x2_out_row;
    logic [9:0]  x2_out_col;
    logic        frame_end;
  } res_t;

endpackage

// ===== hw/rtl/flux_ct_emf_stencil_unit.sv =====
`timescale 1ns / 1ps

// two register stages (input stage, result register); a result moves from the input stage
// into the result register when the output side is ready
// throughput: one zone per cycle; the two line buffers take one read and one write each cycle
// a waiting result stalls the input side once the input stage behind it is also full
// reset (rst, synchronous, active high) clears the raster position, valid flags and sizes (256)
// line buffer contents are not cleared; no result uses a value that was not written in that frame
module flux_ct_emf_stencil_unit (
  input  logic                               clk,
  input  logic                               rst,
  // apb-style configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fct_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [fct_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [fct_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  // zone flux stream
  input  logic                               src_valid,
  output logic                               src_ready,
  input  fct_pkg::src_t                      src_data,
  // rewritten flux stream
  output logic                               res_valid,
  input  logic                               res_ready,
  output fct_pkg::res_t                      res_data
);

  import fct_pkg::*;

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic [CFG_W-1:0] cols_in_use;
  logic [CFG_W-1:0] rows_in_use;
  logic             cfg_write;
  reg_idx_t         cfg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= COLS_RESET;
      rows_in_use <= ROWS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_COLS: cols_in_use <= pwdata[CFG_W-1:0];
        REG_ROWS: rows_in_use <= pwdata[CFG_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_COLS: prdata = APB_DATA_W'(cols_in_use);
      REG_ROWS: prdata = APB_DATA_W'(rows_in_use);
      default:  prdata = '0;
    endcase
  end

  // effective sizes: zero acts as one, anything above the maximum is clamped
  logic [POS_W-1:0] n_cols;
  logic [POS_W-1:0] n_rows;

  always_comb begin
    priority if (cols_in_use == '0)
      n_cols = POS_W'(1);
    else if (cols_in_use > CFG_W'(MAX_COLS))
      n_cols = POS_W'(MAX_COLS);
    else
      n_cols = POS_W'(cols_in_use);
    priority if (rows_in_use == '0)
      n_rows = POS_W'(1);
    else if (rows_in_use > CFG_W'(MAX_ROWS))
      n_rows = POS_W'(MAX_ROWS);
    else
      n_rows = POS_W'(rows_in_use);
  end

  // ---------------------------------------------------------------
  // handshake: input stage a, result register
  // ---------------------------------------------------------------
  logic a_valid;
  logic a_fire;
  logic src_xfer;

  // stage a moves on when the result register is empty or being drained
  assign a_fire    = a_valid && (!res_valid || res_ready);
  assign src_ready = !a_valid || a_fire;
  assign src_xfer  = src_valid && src_ready;

  // ---------------------------------------------------------------
  // raster position (position plus one, zero is the ghost row / column)
  // ---------------------------------------------------------------
  logic [POS_W-1:0] col_position;
  logic [POS_W-1:0] row_position;
  logic [POS_W-1:0] col_position_next;
  logic [POS_W-1:0] row_position_next;
  logic             wrap_frame;

  always_comb begin
    col_position_next = col_position + POS_W'(1);
    row_position_next = row_position;
    wrap_frame        = 1'b0;
    if (col_position >= n_cols + POS_W'(1)) begin
      col_position_next = '0;
      if (row_position >= n_rows + POS_W'(1)) begin
        row_position_next = '0;
        wrap_frame        = 1'b1;
      end else begin
        row_position_next = row_position + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_position <= '0;
      row_position <= '0;
    end else if (src_xfer) begin
      col_position <= col_position_next;
      row_position <= row_position_next;
    end
  end

  // which results this zone gives, decided at transfer time
  logic             emf_ok;
  logic             x1_ok;
  logic             x2_ok;
  logic [EMF_AW-1:0] emf_addr;

  always_comb begin
    emf_ok = (row_position != '0) && (col_position != '0);
    // x1 face below this corner row: row r-1 >= 0, column c <= n_cols
    x1_ok  = emf_ok && (row_position >= POS_W'(2))
             && (row_position <= n_rows + POS_W'(1))
             && (col_position <= n_cols + POS_W'(1));
    // x2 face left of this corner column: column c-1 >= 0
    x2_ok  = emf_ok && (row_position <= n_rows + POS_W'(1))
             && (col_position >= POS_W'(2))
             && (col_position <= n_cols + POS_W'(1));
    emf_addr = emf_ok ? EMF_AW'(col_position - POS_W'(1)) : '0;
  end

  // ---------------------------------------------------------------
  // line buffers: previous row's x1 fluxes and corner emfs
  // ---------------------------------------------------------------
  flux_t x1_line  [X1_DEPTH];
  flux_t emf_line [EMF_DEPTH];
  flux_t x1_rd;
  flux_t emf_rd;

  // stage a registers
  flux_t             a_f1;
  flux_t             a_f2;
  flux_t             a_prev_x2;
  logic [POS_W-1:0]  a_col;
  logic [POS_W-1:0]  a_row;
  logic [EMF_AW-1:0] a_emf_addr;
  logic              a_emf_ok;
  logic              a_x1_ok;
  logic              a_x2_ok;
  logic              a_frame_end;

  // single-entry history of the previous column
  flux_t prior_x2_flux;
  flux_t prior_emf;

  // emf of the zone in stage a
  flux_t emf;

  // reads happen at the input transfer; the same address comes back only a
  // full raster row later, so the write of its last user has always landed
  always_ff @(posedge clk) begin
    if (src_xfer) begin
      x1_rd <= x1_line[X1_AW'(col_position)];
    end
    if (a_fire) begin
      x1_line[X1_AW'(a_col)] <= a_f1;
    end
  end

  always_ff @(posedge clk) begin
    if (src_xfer) begin
      emf_rd <= emf_line[emf_addr];
    end
    if (a_fire && a_emf_ok) begin
      emf_line[a_emf_addr] <= emf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (src_ready) begin
      a_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_xfer) begin
      a_f1          <= src_data.x1_b2_flux;
      a_f2          <= src_data.x2_b1_flux;
      a_prev_x2     <= prior_x2_flux;
      prior_x2_flux <= src_data.x2_b1_flux;
      a_col         <= col_position;
      a_row         <= row_position;
      a_emf_addr    <= emf_addr;
      a_emf_ok      <= emf_ok;
      a_x1_ok       <= x1_ok;
      a_x2_ok       <= x2_ok;
      a_frame_end   <= wrap_frame;
    end
    if (a_fire && a_emf_ok) begin
      prior_emf <= emf;
    end
  end

  // ---------------------------------------------------------------
  // stencil arithmetic
  // ---------------------------------------------------------------
  logic signed [FLUX_BITS+1:0] sum4;
  logic signed [FLUX_BITS+1:0] quarter;
  logic signed [FLUX_BITS:0]   pair_x1;
  logic signed [FLUX_BITS:0]   half_x1;
  logic signed [FLUX_BITS+1:0] neg_pair;
  logic signed [FLUX_BITS+1:0] neg_half;
  flux_t                       new_x2;

  always_comb begin
    // exact four-term sum, floored quarter always fits the flux width
    sum4    = (FLUX_BITS+2)'(a_f1) + (FLUX_BITS+2)'(x1_rd)
              - (FLUX_BITS+2)'(a_f2) - (FLUX_BITS+2)'(a_prev_x2);
    quarter = sum4 >>> 2;
    emf     = flux_t'(quarter[FLUX_BITS-1:0]);

    pair_x1 = (FLUX_BITS+1)'(emf_rd) + (FLUX_BITS+1)'(emf);
    half_x1 = pair_x1 >>> 1;

    // negated half-sum; only two most-negative emfs overflow, saturate high
    neg_pair = -((FLUX_BITS+2)'(prior_emf) + (FLUX_BITS+2)'(emf));
    neg_half = neg_pair >>> 1;
    if (neg_half[FLUX_BITS-1] != neg_half[FLUX_BITS+1])
      new_x2 = {1'b0, {(FLUX_BITS-1){1'b1}}};
    else
      new_x2 = flux_t'(neg_half[FLUX_BITS-1:0]);
  end

  // ---------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------
  res_t res_next;

  always_comb begin
    res_next = '0;
    if (a_x1_ok) begin
      res_next.new_x1_b2    = flux_t'(half_x1[FLUX_BITS-1:0]);
      res_next.x1_out_valid = 1'b1;
      res_next.x1_out_row   = 10'(a_row - POS_W'(2));
      res_next.x1_out_col   = 11'(a_col - POS_W'(1));
    end
    if (a_x2_ok) begin
      res_next.new_x2_b1    = new_x2;
      res_next.x2_out_valid = 1'b1;
      res_next.x2_out_row   = 11'(a_row - POS_W'(1));
      res_next.x2_out_col   = 10'(a_col - POS_W'(2));
    end
    res_next.frame_end = a_frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || res_ready) begin
      res_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      res_data <= res_next;
    end
  end

`ifndef SYNTH
  // the raster position never runs past the widest row
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col_position <= POS_W'(MAX_COLS + 1))
    else $error("column position beyond line buffer");

  // an empty input stage always takes a transfer
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !a_valid |-> src_ready)
    else $error("input stage empty but not ready");

  // an x2 result needs a left neighbor corner in the ghost-free grid
  a_x2_needs_left: assert property (@(posedge clk) disable iff (rst)
    (a_fire && a_x2_ok) |-> (a_col >= POS_W'(2) && a_emf_ok))
    else $error("x2 result without a left corner");

  // nothing leaves right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");
`endif

endmodule
